/* hdl/gsa_pkg.sv */
`timescale 1ns / 1ps
package gsa_pkg;

  localparam int unsigned MAX_SLOTS = 256;
  localparam int unsigned IDX_W     = 8;
  localparam int unsigned CNT_W     = 9;

  localparam logic [CNT_W-1:0] MAX_CNT   = CNT_W'(MAX_SLOTS);
  localparam logic [CNT_W-1:0] CAP_RESET = CNT_W'(64);

  localparam logic [2:0] CMD_REGISTER = 3'd0;
  localparam logic [2:0] CMD_LOOKUP   = 3'd1;
  localparam logic [2:0] CMD_UPDATE   = 3'd2;
  localparam logic [2:0] CMD_RELEASE  = 3'd3;
  localparam logic [2:0] CMD_RECLAIM  = 3'd4;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_INVALID = 2'd1;
  localparam logic [1:0] ST_NO_SLOT = 2'd2;

  // controller -> datapath
  typedef struct packed {
    logic       latch;
    logic       grow;
    logic       alloc;
    logic       check;
    logic       rc_init;
    logic       rc_step;
    logic       rc_end;
    logic       fail;
    logic [1:0] fail_code;
  } gsa_op_t;

  // datapath -> controller
  typedef struct packed {
    logic [2:0] cmd;
    logic       stack_empty;
    logic       can_grow;
    logic       rc_more;
  } gsa_stat_t;

endpackage

/* hdl/gsa_dpath.sv */
`timescale 1ns / 1ps
module gsa_dpath #(
  parameter int DataBits = 64
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [gsa_pkg::CNT_W-1:0]    cfg_wdata_i,
  input  logic [2:0]                   command_i,
  input  logic [gsa_pkg::IDX_W-1:0]    handle_index_i,
  input  logic [31:0]                  handle_generation_i,
  input  logic [DataBits-1:0]          item_payload_i,
  input  logic [63:0]                  fence_i,
  input  gsa_pkg::gsa_op_t             op_i,
  output gsa_pkg::gsa_stat_t           stat_o,
  output logic [1:0]                   status_o,
  output logic [gsa_pkg::IDX_W-1:0]    out_index_o,
  output logic [31:0]                  out_generation_o,
  output logic [DataBits-1:0]          out_payload_o,
  output logic [gsa_pkg::CNT_W-1:0]    reclaimed_count_o,
  output logic [gsa_pkg::CNT_W-1:0]    active_count_o,
  output logic [gsa_pkg::CNT_W-1:0]    pending_count_o,
  output logic [gsa_pkg::CNT_W-1:0]    current_capacity_o
);
  import gsa_pkg::*;

  // latched request
  logic [2:0]          cmd_q;
  logic [IDX_W-1:0]    idx_q;
  logic [31:0]         hgen_q;
  logic [DataBits-1:0] pay_q;
  logic [63:0]         fence_q;

  // table state
  logic [CNT_W-1:0]     cap_q, depth_q, pd_q, total_q, r_q, w_q;
  logic [IDX_W-1:0]     vtop_q;
  logic [31:0]          gencnt_q;
  logic [MAX_SLOTS-1:0] in_use_q, svalid_q;

  // result
  logic [1:0]          res_status_q;
  logic [IDX_W-1:0]    res_idx_q;
  logic [31:0]         res_gen_q;
  logic [DataBits-1:0] res_pay_q;
  logic [CNT_W-1:0]    res_rec_q;

  // memories
  logic [DataBits-1:0] data_mem   [MAX_SLOTS];
  logic [31:0]         gen_mem    [MAX_SLOTS];
  logic [IDX_W-1:0]    stack_mem  [MAX_SLOTS];
  logic [IDX_W-1:0]    pslot_mem  [MAX_SLOTS];
  logic [63:0]         pfence_mem [MAX_SLOTS];

  logic [DataBits-1:0] data_rd_q;
  logic [31:0]         gen_rd_q;
  logic [IDX_W-1:0]    stk_rd_q, ps_rd_q;
  logic [63:0]         pf_rd_q;

  logic [IDX_W-1:0] pop_pos, alloc_idx, pw_addr, pw_slot, data_wa;
  logic [63:0]      pw_fence;
  logic [CNT_W:0]   cap2;
  logic [CNT_W-1:0] grown, cfg_cap;
  logic chk_ok, upd_wr, rel, rel_push, rc_hit, rc_push, pw_en, data_we;

  always_comb begin
    pop_pos   = depth_q[IDX_W-1:0] - IDX_W'(1);
    // unwritten stack entries hold the descending fill from vtop down
    alloc_idx = svalid_q[pop_pos] ? stk_rd_q : vtop_q - pop_pos;
    cap2      = {cap_q, 1'b0};
    grown     = (cap2 > {1'b0, MAX_CNT}) ? MAX_CNT : cap2[CNT_W-1:0];
    cfg_cap   = (cfg_wdata_i > MAX_CNT) ? MAX_CNT : cfg_wdata_i;
    chk_ok    = ({1'b0, idx_q} < cap_q) && in_use_q[idx_q] && (gen_rd_q == hgen_q);
    upd_wr    = op_i.check && chk_ok && (cmd_q == CMD_UPDATE);
    rel       = op_i.check && chk_ok && (cmd_q == CMD_RELEASE);
    rel_push  = rel && (pd_q < MAX_CNT);
    rc_hit    = fence_q >= pf_rd_q;
    rc_push   = op_i.rc_step && rc_hit && ({1'b0, ps_rd_q} < cap_q) && (depth_q < MAX_CNT);
    pw_en     = rel_push || (op_i.rc_step && !rc_hit);
    pw_addr   = rel ? pd_q[IDX_W-1:0] : w_q[IDX_W-1:0];
    pw_slot   = rel ? idx_q : ps_rd_q;
    pw_fence  = rel ? fence_q : pf_rd_q;
    data_we   = op_i.alloc || upd_wr;
    data_wa   = op_i.alloc ? alloc_idx : idx_q;
  end

  assign stat_o.cmd         = cmd_q;
  assign stat_o.stack_empty = (depth_q == '0);
  assign stat_o.can_grow    = (cap_q != '0) && (cap_q < MAX_CNT);
  assign stat_o.rc_more     = (r_q != pd_q);

  always_ff @(posedge clk_i) begin
    data_rd_q <= data_mem[idx_q];
    gen_rd_q  <= gen_mem[idx_q];
    stk_rd_q  <= stack_mem[pop_pos];
    ps_rd_q   <= pslot_mem[r_q[IDX_W-1:0]];
    pf_rd_q   <= pfence_mem[r_q[IDX_W-1:0]];
    if (data_we) begin
      data_mem[data_wa] <= pay_q;
    end
    if (op_i.alloc) begin
      gen_mem[alloc_idx] <= gencnt_q;
    end
    if (rc_push) begin
      stack_mem[depth_q[IDX_W-1:0]] <= ps_rd_q;
    end
    if (pw_en) begin
      pslot_mem[pw_addr]  <= pw_slot;
      pfence_mem[pw_addr] <= pw_fence;
    end
  end

  always_ff @(posedge clk_i) begin
    if (op_i.latch) begin
      cmd_q        <= command_i;
      idx_q        <= handle_index_i;
      hgen_q       <= handle_generation_i;
      pay_q        <= item_payload_i;
      fence_q      <= fence_i;
      res_status_q <= ST_OK;
      res_idx_q    <= '0;
      res_gen_q    <= '0;
      res_pay_q    <= '0;
      res_rec_q    <= '0;
    end else begin
      if (op_i.fail) begin
        res_status_q <= op_i.fail_code;
      end
      if (op_i.check && !chk_ok) begin
        res_status_q <= ST_INVALID;
      end
      if (op_i.check && chk_ok && (cmd_q == CMD_LOOKUP)) begin
        res_pay_q <= data_rd_q;
      end
      if (op_i.alloc) begin
        res_idx_q <= alloc_idx;
        res_gen_q <= gencnt_q;
      end
      if (op_i.rc_step && rc_hit) begin
        res_rec_q <= res_rec_q + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q    <= CAP_RESET;
      depth_q  <= CAP_RESET;
      vtop_q   <= CAP_RESET[IDX_W-1:0] - IDX_W'(1);
      svalid_q <= '0;
      in_use_q <= '0;
      gencnt_q <= 32'd1;
      pd_q     <= '0;
      total_q  <= '0;
      r_q      <= '0;
      w_q      <= '0;
    end else if (cfg_we_i) begin
      cap_q    <= cfg_cap;
      depth_q  <= cfg_cap;
      vtop_q   <= cfg_cap[IDX_W-1:0] - IDX_W'(1);
      svalid_q <= '0;
      in_use_q <= '0;
      gencnt_q <= 32'd1;
      pd_q     <= '0;
      total_q  <= '0;
    end else begin
      if (op_i.grow) begin
        cap_q    <= grown;
        depth_q  <= grown - cap_q;
        vtop_q   <= grown[IDX_W-1:0] - IDX_W'(1);
        svalid_q <= '0;
      end
      if (op_i.alloc) begin
        depth_q             <= depth_q - CNT_W'(1);
        in_use_q[alloc_idx] <= 1'b1;
        total_q             <= total_q + CNT_W'(1);
        gencnt_q            <= gencnt_q + 32'd1;
      end
      if (rel) begin
        in_use_q[idx_q] <= 1'b0;
        total_q         <= total_q - CNT_W'(1);
        if (rel_push) begin
          pd_q <= pd_q + CNT_W'(1);
        end
      end
      if (op_i.rc_init) begin
        r_q <= '0;
        w_q <= '0;
      end
      if (op_i.rc_step) begin
        r_q <= r_q + CNT_W'(1);
        if (rc_push) begin
          depth_q                         <= depth_q + CNT_W'(1);
          svalid_q[depth_q[IDX_W-1:0]]    <= 1'b1;
        end
        if (!rc_hit) begin
          w_q <= w_q + CNT_W'(1);
        end
      end
      if (op_i.rc_end) begin
        pd_q <= w_q;
      end
    end
  end

  assign status_o           = res_status_q;
  assign out_index_o        = res_idx_q;
  assign out_generation_o   = res_gen_q;
  assign out_payload_o      = res_pay_q;
  assign reclaimed_count_o  = res_rec_q;
  assign active_count_o     = total_q;
  assign pending_count_o    = pd_q;
  assign current_capacity_o = cap_q;

endmodule

/* hdl/gsa_ctrl.sv */
`timescale 1ns / 1ps
module gsa_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  gsa_pkg::gsa_stat_t stat_i,
  output gsa_pkg::gsa_op_t   op_o,
  output logic               busy_o,
  output logic               done_o
);
  import gsa_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_DISPATCH, S_POP_WAIT, S_POP, S_CHECK, S_RC_READ, S_RC_EVAL
  } state_e;

  state_e state_q, state_d;
  logic   done_q, done_d;

  always_comb begin
    op_o    = '0;
    state_d = state_q;
    done_d  = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          op_o.latch = 1'b1;
          state_d    = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        unique case (stat_i.cmd)
          CMD_REGISTER: begin
            if (stat_i.stack_empty && !stat_i.can_grow) begin
              op_o.fail      = 1'b1;
              op_o.fail_code = ST_NO_SLOT;
              done_d         = 1'b1;
              state_d        = S_IDLE;
            end else begin
              op_o.grow = stat_i.stack_empty;
              state_d   = S_POP_WAIT;
            end
          end
          CMD_LOOKUP, CMD_UPDATE, CMD_RELEASE: begin
            state_d = S_CHECK;
          end
          CMD_RECLAIM: begin
            op_o.rc_init = 1'b1;
            state_d      = S_RC_READ;
          end
          default: begin
            op_o.fail      = 1'b1;
            op_o.fail_code = ST_INVALID;
            done_d         = 1'b1;
            state_d        = S_IDLE;
          end
        endcase
      end
      S_POP_WAIT: state_d = S_POP;
      S_POP: begin
        op_o.alloc = 1'b1;
        done_d     = 1'b1;
        state_d    = S_IDLE;
      end
      S_CHECK: begin
        op_o.check = 1'b1;
        done_d     = 1'b1;
        state_d    = S_IDLE;
      end
      S_RC_READ: begin
        if (stat_i.rc_more) begin
          state_d = S_RC_EVAL;
        end else begin
          op_o.rc_end = 1'b1;
          done_d      = 1'b1;
          state_d     = S_IDLE;
        end
      end
      S_RC_EVAL: begin
        op_o.rc_step = 1'b1;
        state_d      = S_RC_READ;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  assign busy_o = (state_q != S_IDLE);
  assign done_o = done_q;

endmodule

/* hdl/generational_slot_allocator.sv */
`timescale 1ns / 1ps
// Generational slot allocator. A request is taken when start is high and busy
// is low; its result appears for exactly one cycle with result_valid_o high
// and cannot be held off, so the receiver must capture it then. Lookup,
// update and release go from dispatch to the check state (one memory read,
// then the check); a successful register goes from dispatch through a wait
// state for the free stack read to the pop state, growth being done in
// dispatch; a failing register or an unknown command ends in dispatch. A
// reclaim walks the pending queue through its single read port, with a read
// state and an evaluation state per entry. A new request may be accepted in
// the strobe cycle. Writing the capacity register re-initialises the whole
// table at once (valid flags, no clearing pass); write it only while idle.
module generational_slot_allocator #(
  parameter int DataBits = 64
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [gsa_pkg::CNT_W-1:0] cfg_wdata_i,
  input  logic                      start,
  output logic                      busy,
  input  logic [2:0]                command_i,
  input  logic [gsa_pkg::IDX_W-1:0] handle_index_i,
  input  logic [31:0]               handle_generation_i,
  input  logic [DataBits-1:0]       item_payload_i,
  input  logic [63:0]               fence_i,
  output logic                      result_valid_o,
  output logic [1:0]                status_o,
  output logic [gsa_pkg::IDX_W-1:0] out_index_o,
  output logic [31:0]               out_generation_o,
  output logic [DataBits-1:0]       out_payload_o,
  output logic [gsa_pkg::CNT_W-1:0] reclaimed_count_o,
  output logic [gsa_pkg::CNT_W-1:0] active_count_o,
  output logic [gsa_pkg::CNT_W-1:0] pending_count_o,
  output logic [gsa_pkg::CNT_W-1:0] current_capacity_o
);
  import gsa_pkg::*;

  gsa_op_t   op;
  gsa_stat_t stat;

  // sequencer: one request at a time
  gsa_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .stat_i  (stat),
    .op_o    (op),
    .busy_o  (busy),
    .done_o  (result_valid_o)
  );

  // tables, free stack, pending queue and result registers
  gsa_dpath #(
    .DataBits (DataBits)
  ) u_dpath (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_we_i            (cfg_we_i),
    .cfg_wdata_i         (cfg_wdata_i),
    .command_i           (command_i),
    .handle_index_i      (handle_index_i),
    .handle_generation_i (handle_generation_i),
    .item_payload_i      (item_payload_i),
    .fence_i             (fence_i),
    .op_i                (op),
    .stat_o              (stat),
    .status_o            (status_o),
    .out_index_o         (out_index_o),
    .out_generation_o    (out_generation_o),
    .out_payload_o       (out_payload_o),
    .reclaimed_count_o   (reclaimed_count_o),
    .active_count_o      (active_count_o),
    .pending_count_o     (pending_count_o),
    .current_capacity_o  (current_capacity_o)
  );

  // result strobe only once the sequencer is back at rest
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> !busy)
    else $error("result strobe while busy");

  // an accepted request always occupies the sequencer next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy)
    else $error("request accepted but sequencer idle");

  // live slots never exceed the usable capacity
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    active_count_o <= current_capacity_o)
    else $error("active count above capacity");

  // reclaimed count is only reported for a successful reclaim
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && (reclaimed_count_o != '0) |-> status_o == ST_OK)
    else $error("reclaim count with failure status");

endmodule

/* bench/testbench.sv */
`timescale 1ns / 1ps
module testbench;
  import gsa_pkg::*;

  typedef struct {
    logic [1:0]  status;
    logic [7:0]  index;
    logic [31:0] generation;
    logic [63:0] payload;
    logic [8:0]  reclaimed;
    logic [8:0]  active;
    logic [8:0]  pending;
    logic [8:0]  capacity;
  } alloc_result_t;

  class slot_table_sb;
    logic [63:0]   data [256];
    logic [31:0]   gen [256];
    bit            used [256];
    int unsigned   stack [256];
    int unsigned   depth, cap, gen_ctr, pend_n, live;
    int unsigned   pend_slot [256];
    logic [63:0]   pend_fence [256];
    alloc_result_t due [$];
    bit            failed;

    function void configure(int unsigned value);
      cap = (value > MAX_SLOTS) ? MAX_SLOTS : value;
      foreach (used[k]) used[k] = 0;
      for (int unsigned k = 0; k < cap; k++) stack[k] = cap - 1 - k;
      depth = cap;
      gen_ctr = 1;
      pend_n = 0;
      live = 0;
    endfunction

    function bit handle_good(int unsigned idx, logic [31:0] g);
      return idx < cap && used[idx] && gen[idx] == g;
    endfunction

    // Apply one accepted request and queue the result it must produce.
    function void note(logic [2:0] cmd, logic [7:0] idx, logic [31:0] g,
                       logic [63:0] pay, logic [63:0] fen);
      alloc_result_t r;
      int unsigned s, grown, w;
      r = '{default: '0};
      case (cmd)
        CMD_REGISTER: begin
          if (depth == 0 && cap > 0 && cap < MAX_SLOTS) begin
            grown = (cap * 2 > MAX_SLOTS) ? MAX_SLOTS : cap * 2;
            for (int unsigned i = grown; i > cap; i--) stack[depth++] = i - 1;
            cap = grown;
          end
          if (depth == 0) begin
            r.status = ST_NO_SLOT;
          end else begin
            s = stack[--depth];
            data[s] = pay;
            gen[s] = gen_ctr;
            gen_ctr++;
            used[s] = 1;
            live++;
            r.index = 8'(s);
            r.generation = gen[s];
          end
        end
        CMD_LOOKUP: begin
          if (handle_good(32'(idx), g)) r.payload = data[idx];
          else r.status = ST_INVALID;
        end
        CMD_UPDATE: begin
          if (handle_good(32'(idx), g)) data[idx] = pay;
          else r.status = ST_INVALID;
        end
        CMD_RELEASE: begin
          if (handle_good(32'(idx), g)) begin
            pend_slot[pend_n] = 32'(idx);
            pend_fence[pend_n] = fen;
            pend_n++;
            used[idx] = 0;
            live--;
          end else begin
            r.status = ST_INVALID;
          end
        end
        CMD_RECLAIM: begin
          w = 0;
          for (int unsigned k = 0; k < pend_n; k++) begin
            if (fen >= pend_fence[k]) begin
              s = pend_slot[k];
              if (s < cap) begin
                data[s] = '0;
                used[s] = 0;
                stack[depth++] = s;
              end
              r.reclaimed++;
            end else begin
              pend_slot[w] = pend_slot[k];
              pend_fence[w] = pend_fence[k];
              w++;
            end
          end
          pend_n = w;
        end
        default: r.status = ST_INVALID;
      endcase
      r.active = 9'(live);
      r.pending = 9'(pend_n);
      r.capacity = 9'(cap);
      due.insert(due.size(), r);
    endfunction

    function void check(alloc_result_t got);
      alloc_result_t e;
      if (due.size() == 0) begin
        $error("result strobe with nothing outstanding");
        failed = 1;
        return;
      end
      e = due.pop_front();
      if (got.status !== e.status) begin
        $error("status: expected %0d, got %0d", e.status, got.status); failed = 1;
      end
      if (got.index !== e.index) begin
        $error("out_index: expected %0d, got %0d", e.index, got.index); failed = 1;
      end
      if (got.generation !== e.generation) begin
        $error("out_generation: expected %0h, got %0h", e.generation, got.generation);
        failed = 1;
      end
      if (got.payload !== e.payload) begin
        $error("out_payload: expected %0h, got %0h", e.payload, got.payload); failed = 1;
      end
      if (got.reclaimed !== e.reclaimed) begin
        $error("reclaimed_count: expected %0d, got %0d", e.reclaimed, got.reclaimed);
        failed = 1;
      end
      if (got.active !== e.active) begin
        $error("active_count: expected %0d, got %0d", e.active, got.active); failed = 1;
      end
      if (got.pending !== e.pending) begin
        $error("pending_count: expected %0d, got %0d", e.pending, got.pending); failed = 1;
      end
      if (got.capacity !== e.capacity) begin
        $error("current_capacity: expected %0d, got %0d", e.capacity, got.capacity);
        failed = 1;
      end
    endfunction
  endclass

  logic        clk_i = 0;
  logic        rst_ni = 0;
  logic        cfg_we = 0;
  logic [8:0]  cfg_wdata = '0;
  logic        start = 0;
  logic        busy;
  logic [2:0]  command = '0;
  logic [7:0]  h_index = '0;
  logic [31:0] h_gen = '0;
  logic [63:0] payload = '0;
  logic [63:0] fence = '0;
  logic        res_valid;
  alloc_result_t seen;

  logic [1:0]  status_o;
  logic [7:0]  out_index_o;
  logic [31:0] out_generation_o;
  logic [63:0] out_payload_o;
  logic [8:0]  reclaimed_o, active_o, pending_o, capacity_o;

  slot_table_sb sb;
  int unsigned  idle_cycles = 0;
  logic [63:0]  fence_clock = 0;   // rough "GPU progress" for fence values

  generational_slot_allocator uut (
    .clk_i, .rst_ni,
    .cfg_we_i(cfg_we), .cfg_wdata_i(cfg_wdata),
    .start, .busy,
    .command_i(command), .handle_index_i(h_index), .handle_generation_i(h_gen),
    .item_payload_i(payload), .fence_i(fence),
    .result_valid_o(res_valid), .status_o, .out_index_o, .out_generation_o,
    .out_payload_o, .reclaimed_count_o(reclaimed_o), .active_count_o(active_o),
    .pending_count_o(pending_o), .current_capacity_o(capacity_o)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // Results cannot be stalled, so every strobe is checked on the edge ending it.
  always @(posedge clk_i) begin
    if (rst_ni && res_valid) begin
      seen.status = status_o;
      seen.index = out_index_o;
      seen.generation = out_generation_o;
      seen.payload = out_payload_o;
      seen.reclaimed = reclaimed_o;
      seen.active = active_o;
      seen.pending = pending_o;
      seen.capacity = capacity_o;
      sb.check(seen);
    end
  end

  // Watchdog: a reclaim over a full queue is the longest request; allow plenty more.
  always @(posedge clk_i) begin
    if ((start && !busy) || res_valid || !rst_ni) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 5000) begin
      $display("testbench: FAIL");
      $finish;
    end
  end

  // Called just after a rising edge; returns on the edge that takes the request.
  task automatic send(logic [2:0] c, logic [7:0] i, logic [31:0] g,
                      logic [63:0] p, logic [63:0] f);
    start <= 1;
    command <= c;
    h_index <= i;
    h_gen <= g;
    payload <= p;
    fence <= f;
    do @(posedge clk_i); while (busy);
    sb.note(c, i, g, p, f);
  endtask

  task automatic pause(int unsigned n);
    start <= 0;
    command <= 3'($urandom);
    repeat (n) @(posedge clk_i);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Pick a handle: mostly a live one, else stale, out of range or random.
  task automatic pick_handle(output logic [7:0] i, output logic [31:0] g);
    int unsigned sel;
    sel = $urandom_range(0, 9);
    i = 8'($urandom_range(0, (sb.cap > 0) ? sb.cap - 1 : 0));
    for (int n = 0; n < 8 && sel < 7 && !sb.used[i]; n++)
      i = 8'($urandom_range(0, (sb.cap > 0) ? sb.cap - 1 : 0));
    g = sb.used[i] ? sb.gen[i] : $urandom;
    if (sel == 7) g = g ^ (32'd1 << $urandom_range(0, 31));
    if (sel == 8) i = 8'($urandom);
    if (sel == 9) g = $urandom;
  endtask

  task automatic random_request();
    logic [7:0]  i;
    logic [31:0] g;
    logic [63:0] f;
    int unsigned pick;
    logic [2:0]  c;
    pick = $urandom_range(0, 99);
    pick_handle(i, g);
    fence_clock = fence_clock + $urandom_range(0, 3);
    if (pick < 30) c = CMD_REGISTER;
    else if (pick < 48) c = CMD_LOOKUP;
    else if (pick < 62) c = CMD_UPDATE;
    else if (pick < 84) c = CMD_RELEASE;
    else if (pick < 96) c = CMD_RECLAIM;
    else c = 3'($urandom_range(5, 7));
    if (c == CMD_RELEASE) f = fence_clock + $urandom_range(0, 30);
    else f = fence_clock;
    if ($urandom_range(0, 40) == 0) f = rand64();
    if ($urandom_range(0, 60) == 0) f = '1;
    send(c, i, g, rand64(), f);
  endtask

  // Bursts of back-to-back requests split by random gaps.
  task automatic random_phase(int unsigned n);
    int unsigned burst;
    while (n > 0) begin
      burst = $urandom_range(1, 24);
      while (burst > 0 && n > 0) begin
        random_request();
        burst--;
        n--;
      end
      if ($urandom_range(0, 3) != 0) pause($urandom_range(1, 7));
    end
  endtask

  // Register writes only once the block has drained.
  task automatic set_capacity(int unsigned v);
    pause(1);
    while (sb.due.size() != 0) @(posedge clk_i);
    repeat (12) @(posedge clk_i);
    cfg_we <= 1;
    cfg_wdata <= 9'(v);
    @(posedge clk_i);
    cfg_we <= 0;
    sb.configure(v);
  endtask

  task automatic directed();
    // capacity 1: forces growth 1 -> 2 -> 4
    send(CMD_REGISTER, 8'd0, 32'd0, 64'h0, 64'h0);
    send(CMD_REGISTER, 8'hff, '1, '1, '1);
    send(CMD_REGISTER, 8'd0, 32'd0, 64'h8000_0000_0000_0001, 64'h0);
    send(CMD_LOOKUP, 8'd1, sb.gen[1], 64'h0, '1);
    send(CMD_LOOKUP, 8'd1, sb.gen[1] ^ 32'h8000_0000, 64'h0, 64'h0);
    send(CMD_LOOKUP, 8'hff, 32'd1, 64'h0, 64'h0);       // index beyond capacity
    send(CMD_LOOKUP, 8'd3, 32'd0, 64'h0, 64'h0);        // slot never in use
    send(CMD_UPDATE, 8'd2, sb.gen[2], 64'h1234_5678_9abc_def0, 64'h0);
    send(CMD_LOOKUP, 8'd2, sb.gen[2], 64'h0, 64'h0);
    send(CMD_RELEASE, 8'd0, sb.gen[0], 64'h0, 64'd5);
    send(CMD_RELEASE, 8'd0, 32'd1, 64'h0, 64'd5);       // double release
    send(CMD_LOOKUP, 8'd0, 32'd1, 64'h0, 64'h0);        // stale handle
    send(CMD_RELEASE, 8'd1, sb.gen[1], 64'h0, '1);
    send(CMD_RECLAIM, 8'd0, 32'd0, 64'h0, 64'd4);       // nothing due yet
    send(CMD_RECLAIM, 8'd0, 32'd0, 64'h0, 64'd5);       // frees slot 0 only
    send(3'd5, 8'd0, 32'd0, 64'h0, 64'h0);
    send(3'd7, 8'hff, '1, '1, '1);
    send(CMD_REGISTER, 8'd0, 32'd0, 64'hdead_beef_0000_ffff, 64'h0);
    send(CMD_REGISTER, 8'd0, 32'd0, 64'h0, 64'h0);
    send(CMD_REGISTER, 8'd0, 32'd0, 64'h0, 64'h0);      // grows to 8
    send(CMD_RECLAIM, 8'd0, 32'd0, 64'h0, '1);
    send(CMD_UPDATE, 8'd5, 32'd0, '1, 64'h0);           // invalid update
    send(CMD_REGISTER, 8'd0, 32'd0, 64'h0, 64'h0);
  endtask

  initial begin
    sb = new();
    sb.configure(CAP_RESET);
    repeat (12) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    random_phase(100);                   // reset capacity of 64
    set_capacity(1);
    directed();
    random_phase(70);
    set_capacity(0);                     // every register fails
    random_phase(40);
    set_capacity(256);
    random_phase(130);
    set_capacity(511);                   // clipped to the maximum
    random_phase(70);
    set_capacity(2);
    random_phase(110);
    set_capacity(3);
    random_phase(80);
    set_capacity(100);
    random_phase(80);

    pause(1);
    while (sb.due.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (!sb.failed) $display("testbench: PASS");
    else $display("testbench: FAIL");
    $finish;
  end
endmodule

/* generational_slot_allocator.f */
hdl/gsa_pkg.sv
hdl/gsa_dpath.sv
hdl/gsa_ctrl.sv
hdl/generational_slot_allocator.sv
bench/testbench.sv
